@@ hdl/mrid_pkg.sv @@
// Shared widths, constants and types of the masked RMS image difference unit.
package mrid_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CH_N       = 3;
  localparam int unsigned CHC_W      = 2;
  localparam int unsigned SQ_W       = 2 * PIX_W;
  localparam int unsigned SQT_W      = SQ_W + 2;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned CNT_W      = 23;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned NUM_W      = SUM_W + FRAC_W;
  localparam int unsigned ROOT_W     = 17;
  localparam int unsigned QUO_W      = 2 * ROOT_W;
  localparam int unsigned SREM_W     = ROOT_W + 1;
  localparam int unsigned STEP_W     = $clog2(NUM_W);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_W-1:0]  MAX_PIXELS        = CNT_W'(4194304);
  localparam logic [CHC_W-1:0]  CHANNEL_COUNT_RST = CHC_W'(3);
  localparam logic [STEP_W-1:0] DIV_LAST          = STEP_W'(NUM_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST         = STEP_W'(ROOT_W - 1);

  // Totals of one finished frame, handed from the accumulator to the divider.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } frame_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_OUT
  } back_state_e;

endpackage

@@ hdl/mrid_pix_if.sv @@
// Pixel channel: valid/ready handshake carrying one pixel pair and its flags.
interface mrid_pix_if import mrid_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mask_on;
  logic [PIX_W-1:0] first_ch0;
  logic [PIX_W-1:0] first_ch1;
  logic [PIX_W-1:0] first_ch2;
  logic [PIX_W-1:0] second_ch0;
  logic [PIX_W-1:0] second_ch1;
  logic [PIX_W-1:0] second_ch2;
  logic             last_pixel;

  modport source (
    output valid, mask_on, first_ch0, first_ch1, first_ch2,
           second_ch0, second_ch1, second_ch2, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, mask_on, first_ch0, first_ch1, first_ch2,
           second_ch0, second_ch1, second_ch2, last_pixel,
    output ready
  );
endinterface

@@ hdl/mrid_res_if.sv @@
// Result channel: valid/ready handshake carrying one RMS result per frame.
interface mrid_res_if import mrid_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROOT_W-1:0] rms_value;
  logic              empty_mask;

  modport source (
    output valid, rms_value, empty_mask,
    input  ready
  );

  modport sink (
    input  valid, rms_value, empty_mask,
    output ready
  );
endinterface

@@ hdl/mrid_front.sv @@
// Front end: accepts pixels, squares channel differences and accumulates per frame.
module mrid_front import mrid_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CHC_W-1:0] channel_count_i,
  mrid_pix_if.sink         pix_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output frame_t           push_frame_o
);

  logic                          adv;
  logic                          accept;
  logic                          take;
  logic [CNT_W-1:0]              cnt_q;
  logic [CNT_W-1:0]              cnt_inc;
  logic [CH_N-1:0][PIX_W-1:0]    first_px;
  logic [CH_N-1:0][PIX_W-1:0]    second_px;
  logic [CH_N-1:0][PIX_W-1:0]    diff_d;

  logic                          s1_valid_q;
  logic                          s1_last_q;
  logic [CNT_W-1:0]              s1_cnt_q;
  logic [CH_N-1:0][PIX_W-1:0]    s1_diff_q;

  logic                          s2_valid_q;
  logic                          s2_last_q;
  logic [CNT_W-1:0]              s2_cnt_q;
  logic [CH_N-1:0][SQ_W-1:0]     s2_sq_q;

  logic [SQT_W-1:0]              sq_total;
  logic [SUM_W-1:0]              sum_q;
  logic [SUM_W-1:0]              sum_new;

  // The whole pipeline holds while a finished frame waits for room in the queue.
  assign adv         = !(s2_valid_q && s2_last_q && !push_ready_i);
  assign pix_i.ready = adv;
  assign accept      = pix_i.valid && adv;

  // Past the pixel limit a masked pixel is neither summed nor counted.
  assign take    = pix_i.mask_on && (cnt_q < MAX_PIXELS);
  assign cnt_inc = cnt_q + CNT_W'(take);

  assign first_px  = {pix_i.first_ch2, pix_i.first_ch1, pix_i.first_ch0};
  assign second_px = {pix_i.second_ch2, pix_i.second_ch1, pix_i.second_ch0};

  always_comb begin
    for (int k = 0; k < CH_N; k++) begin
      if (take && (CHC_W'(k) < channel_count_i)) begin
        diff_d[k] = (first_px[k] >= second_px[k]) ? (first_px[k] - second_px[k])
                                                  : (second_px[k] - first_px[k]);
      end else begin
        diff_d[k] = '0;
      end
    end
  end

  always_comb begin
    sq_total = '0;
    for (int k = 0; k < CH_N; k++) begin
      sq_total = sq_total + SQT_W'(s2_sq_q[k]);
    end
  end

  assign sum_new = sum_q + SUM_W'(sq_total);

  assign push_valid_o       = s2_valid_q && s2_last_q;
  assign push_frame_o.sum   = sum_new;
  assign push_frame_o.count = s2_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      sum_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= pix_i.last_pixel ? '0 : cnt_inc;
      end
      if (adv) begin
        s1_valid_q <= accept;
        s2_valid_q <= s1_valid_q;
        if (s2_valid_q) begin
          sum_q <= s2_last_q ? '0 : sum_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q <= pix_i.last_pixel;
      s1_cnt_q  <= cnt_inc;
      s1_diff_q <= diff_d;
    end
    if (adv) begin
      s2_last_q <= s1_last_q;
      s2_cnt_q  <= s1_cnt_q;
      for (int k = 0; k < CH_N; k++) begin
        s2_sq_q[k] <= SQ_W'(s1_diff_q[k]) * SQ_W'(s1_diff_q[k]);
      end
    end
  end

endmodule

@@ hdl/mrid_queue.sv @@
// Small frame queue between the accumulator and the divide/root engine.
module mrid_queue import mrid_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  frame_t push_frame_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output frame_t pop_frame_o
);

  frame_t                  slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr_q;
  logic [QPTR_W-1:0]       rd_ptr_q;
  logic [QCNT_W-1:0]       fill_q;
  logic                    push;
  logic                    pop;

  assign push_ready_o = (fill_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_frame_o  = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // The depth is a power of two, so the pointers wrap by themselves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + QCNT_W'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_frame_i;
    end
  end

endmodule

@@ hdl/mrid_back.sv @@
// Back end: bit-serial divide of the frame sum by its count, bit-serial square root.
module mrid_back import mrid_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   pop_valid_i,
  output logic   pop_ready_o,
  input  frame_t pop_frame_i,
  mrid_res_if.source res_o
);

  back_state_e         state_q, state_d;
  logic [NUM_W-1:0]    num_q, num_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0]    div_q, div_d;
  logic [SREM_W-1:0]   srem_q, srem_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                empty_q, empty_d;
  logic                res_valid_q, res_valid_d;
  logic [ROOT_W-1:0]   res_rms_q, res_rms_d;
  logic                res_empty_q, res_empty_d;

  logic [CNT_W:0]      div_shift;
  logic [CNT_W:0]      div_diff;
  logic                div_ge;
  logic [NUM_W-1:0]    div_num;
  logic [SREM_W+1:0]   sq_shift;
  logic [SREM_W+1:0]   sq_trial;
  logic [SREM_W+1:0]   sq_diff;
  logic                sq_ge;

  // Restoring division step: one quotient bit per cycle enters at the bottom of num.
  assign div_shift = {rem_q, num_q[NUM_W-1]};
  assign div_ge    = (div_shift >= {1'b0, div_q});
  assign div_diff  = div_shift - {1'b0, div_q};
  assign div_num   = {num_q[NUM_W-2:0], div_ge};

  // Square root step: two radicand bits per cycle, one root bit out.
  assign sq_shift = {srem_q, num_q[NUM_W-1 -: 2]};
  assign sq_trial = (SREM_W + 2)'({root_q, 2'b01});
  assign sq_ge    = (sq_shift >= sq_trial);
  assign sq_diff  = sq_shift - sq_trial;

  assign res_o.valid      = res_valid_q;
  assign res_o.rms_value  = res_rms_q;
  assign res_o.empty_mask = res_empty_q;

  always_comb begin
    state_d     = state_q;
    num_d       = num_q;
    rem_d       = rem_q;
    div_d       = div_q;
    srem_d      = srem_q;
    root_d      = root_q;
    step_d      = step_q;
    empty_d     = empty_q;
    res_rms_d   = res_rms_q;
    res_empty_d = res_empty_q;
    res_valid_d = res_valid_q && !res_o.ready;
    pop_ready_o = 1'b0;

    case (state_q)
      BK_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          if (pop_frame_i.count == '0) begin
            empty_d = 1'b1;
            root_d  = '0;
            state_d = BK_OUT;
          end else begin
            empty_d = 1'b0;
            num_d   = {pop_frame_i.sum, {FRAC_W{1'b0}}};
            rem_d   = '0;
            div_d   = pop_frame_i.count;
            step_d  = DIV_LAST;
            state_d = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        num_d = div_num;
        rem_d = div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
        if (step_q == '0) begin
          // The quotient fits in QUO_W bits; move it to the top for the root.
          num_d   = {div_num[QUO_W-1:0], {(NUM_W - QUO_W){1'b0}}};
          srem_d  = '0;
          root_d  = '0;
          step_d  = SQRT_LAST;
          state_d = BK_SQRT;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      BK_SQRT: begin
        num_d  = {num_q[NUM_W-3:0], 2'b00};
        srem_d = sq_ge ? sq_diff[SREM_W-1:0] : sq_shift[SREM_W-1:0];
        root_d = {root_q[ROOT_W-2:0], sq_ge};
        if (step_q == '0) begin
          state_d = BK_OUT;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      BK_OUT: begin
        if (!res_valid_q || res_o.ready) begin
          res_valid_d = 1'b1;
          res_rms_d   = root_q;
          res_empty_d = empty_q;
          state_d     = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q       <= num_d;
    rem_q       <= rem_d;
    div_q       <= div_d;
    srem_q      <= srem_d;
    root_q      <= root_d;
    step_q      <= step_d;
    empty_q     <= empty_d;
    res_rms_q   <= res_rms_d;
    res_empty_q <= res_empty_d;
  end

endmodule

@@ hdl/masked_rms_image_difference_unit.sv @@
// Masked RMS image difference: pixel pairs in, one Q9.8 RMS result out per frame.
//
// Pixels arrive on pix_i, one transfer per cycle while ready is high. Each transfer
// carries three channels of two images, a mask bit and a last-pixel flag.
// Channels 0 .. channel_count-1 of every masked-in pixel add their squared
// differences to a running sum, and the pixel is counted once; at most
// 4194304 pixels are counted per frame. The transfer flagged last closes the frame.
// One result per frame leaves on res_o: floor(256 * sqrt(sum / count)),
// or zero with empty_mask set when no pixel was counted.
// The accumulator pipeline registers the channel differences, then their
// squares, and adds them to the running sum. The divide/root engine then
// picks up each frame, makes 56 divide steps and 17 root steps, and loads
// the output register; an empty frame goes straight to the output. A two-frame
// queue lets the next frame stream in meanwhile; pix_i stalls only when frames
// shorter than the engine time pile up. A stall on res_o holds the result in
// its register, and the engine then waits with the next one.
// Reset clears the accumulators, the queue and the result, and sets
// channel_count to 3. Write channel_count only while the unit is idle.
module masked_rms_image_difference_unit import mrid_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CHC_W-1:0] cfg_wdata_i,
  mrid_pix_if.sink         pix_i,
  mrid_res_if.source       res_o
);

  logic [CHC_W-1:0] channel_count_q;
  logic             push_valid;
  logic             push_ready;
  frame_t           push_frame;
  logic             pop_valid;
  logic             pop_ready;
  frame_t           pop_frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_count_q <= CHANNEL_COUNT_RST;
    end else if (cfg_we_i) begin
      channel_count_q <= cfg_wdata_i;
    end
  end

  mrid_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .channel_count_i (channel_count_q),
    .pix_i           (pix_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_frame_o    (push_frame)
  );

  mrid_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_frame_i (push_frame),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_frame_o  (pop_frame)
  );

  mrid_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_frame_i (pop_frame),
    .res_o       (res_o)
  );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench of the masked RMS image difference unit.
`timescale 1ns / 100ps

module tb_top;
  import mrid_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    logic                       mask_on;
    logic [CH_N-1:0][PIX_W-1:0] first_px;
    logic [CH_N-1:0][PIX_W-1:0] second_px;
    logic                       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rms_value;
    logic              empty_mask;
  } rms_result_t;

  typedef enum int unsigned {
    MASK_NONE,
    MASK_ALL,
    MASK_MIXED
  } mask_mode_e;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CHC_W-1:0] cfg_wdata_i;

  mrid_pix_if pix_if ();
  mrid_res_if res_if ();

  masked_rms_image_difference_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_if),
    .res_o       (res_if)
  );

  // Predictor state: running totals of the open frame and the channel setting.
  logic [63:0]      sum_acc;
  logic [63:0]      count_acc;
  logic [CHC_W-1:0] channels_cfg;
  rms_result_t      rms_expected_q[$];

  int unsigned fail_count;
  bit          src_idle_en;
  bit          sink_idle_en;
  int unsigned hold_left;
  int unsigned stall_left;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[ROOT_W-1:0];
  endfunction

  function automatic void predict_pixel(input pixel_t p);
    logic [63:0] sq_total;
    rms_result_t res;
    int          diff;
    sq_total = '0;
    if (p.mask_on && count_acc < 64'(MAX_PIXELS)) begin
      for (int k = 0; k < CH_N; k++) begin
        if (k < int'(channels_cfg)) begin
          diff = int'(p.first_px[k]) - int'(p.second_px[k]);
          sq_total += 64'(diff * diff);
        end
      end
      sum_acc   += sq_total;
      count_acc += 64'd1;
    end
    if (p.last_pixel) begin
      if (count_acc == 0) begin
        res.rms_value  = '0;
        res.empty_mask = 1'b1;
      end else begin
        res.rms_value  = floor_sqrt((sum_acc << FRAC_W) / count_acc);
        res.empty_mask = 1'b0;
      end
      rms_expected_q = {rms_expected_q, res};
      sum_acc   = '0;
      count_acc = '0;
    end
  endfunction

  function automatic logic [PIX_W-1:0] pick_level();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic pixel_t rand_pixel(input mask_mode_e mode, input logic last);
    pixel_t p;
    for (int k = 0; k < CH_N; k++) begin
      p.first_px[k]  = pick_level();
      p.second_px[k] = pick_level();
    end
    case (mode)
      MASK_NONE: p.mask_on = 1'b0;
      MASK_ALL:  p.mask_on = 1'b1;
      default:   p.mask_on = 1'($urandom_range(0, 1));
    endcase
    p.last_pixel = last;
    return p;
  endfunction

  // Drives one pixel and returns at the rising edge of its transfer.
  task automatic send_pixel(input pixel_t p);
    @(negedge clk_i);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      pix_if.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    pix_if.valid      = 1'b1;
    pix_if.mask_on    = p.mask_on;
    pix_if.first_ch0  = p.first_px[0];
    pix_if.first_ch1  = p.first_px[1];
    pix_if.first_ch2  = p.first_px[2];
    pix_if.second_ch0 = p.second_px[0];
    pix_if.second_ch1 = p.second_px[1];
    pix_if.second_ch2 = p.second_px[2];
    pix_if.last_pixel = p.last_pixel;
    do @(posedge clk_i); while (!pix_if.ready);
    predict_pixel(p);
  endtask

  task automatic send_frame(input int unsigned len, input mask_mode_e mode);
    for (int unsigned i = 0; i < len; i++) send_pixel(rand_pixel(mode, i == len - 1));
  endtask

  // The divide and root engine may still hold a frame after the queue empties.
  task automatic wait_idle();
    @(negedge clk_i);
    pix_if.valid = 1'b0;
    wait (rms_expected_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_channel_count(input logic [CHC_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(posedge clk_i);
    channels_cfg = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic test_reset_setting();
    pixel_t p;
    // A frame whose only pixel is masked out reports an empty mask.
    p = rand_pixel(MASK_NONE, 1'b1);
    send_pixel(p);
    p.mask_on    = 1'b1;
    p.first_px   = '1;
    p.second_px  = '0;
    send_pixel(p);
    p.first_px   = '0;
    p.second_px  = '1;
    send_pixel(p);
    p.second_px  = p.first_px;
    send_pixel(p);
    // Masked-out pixels add nothing, and a masked-out last pixel still closes.
    p = rand_pixel(MASK_NONE, 1'b0);
    p.first_px  = '1;
    p.second_px = '0;
    send_pixel(p);
    send_pixel(rand_pixel(MASK_ALL, 1'b0));
    send_pixel(rand_pixel(MASK_NONE, 1'b1));
  endtask

  task automatic test_channel_counts();
    pixel_t p;
    for (int c = 0; c <= 3; c++) begin
      write_channel_count(CHC_W'(c));
      p = rand_pixel(MASK_ALL, 1'b1);
      p.first_px  = {8'h00, 8'hff, 8'hff};
      p.second_px = {8'hff, 8'h00, 8'h00};
      send_pixel(p);
      send_frame(2, MASK_ALL);
    end
  endtask

  // The result side stalls for a long time while short frames keep coming.
  task automatic test_output_backpressure();
    write_channel_count(2'd3);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_frame(1, MASK_ALL);
    hold_left = 400;
    for (int i = 0; i < 11; i++) send_frame(1, MASK_MIXED);
  endtask

  task automatic test_random_frames(input logic [CHC_W-1:0] channels,
                                    input int unsigned     n_items,
                                    input bit              with_idle);
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    mask_mode_e  mode;
    sent = 0;
    write_channel_count(channels);
    while (sent < n_items) begin
      r = $urandom_range(0, 9);
      if (r < 3) len = $urandom_range(1, 2);
      else if (r < 9) len = $urandom_range(3, 20);
      else len = $urandom_range(40, 80);
      r = $urandom_range(0, 7);
      mode = (r == 0) ? MASK_NONE : (r < 3) ? MASK_ALL : MASK_MIXED;
      src_idle_en  = with_idle && ($urandom_range(0, 3) != 0);
      sink_idle_en = with_idle && ($urandom_range(0, 3) != 0);
      send_frame(len, mode);
      sent += len;
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_if.ready = 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
      stall_left   = $urandom_range(0, 4);
      res_if.ready = 1'b0;
    end else begin
      res_if.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    rms_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (rms_expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("ERROR: unexpected result rms_value=%0d empty_mask=%0b",
                   res_if.rms_value, res_if.empty_mask);
      end else begin
        want = rms_expected_q.pop_front();
        if (res_if.rms_value !== want.rms_value || res_if.empty_mask !== want.empty_mask) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("ERROR: rms_value exp %0d got %0d, empty_mask exp %0b got %0b",
                     want.rms_value, res_if.rms_value, want.empty_mask, res_if.empty_mask);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("masked_rms_image_difference_unit test failed");
    $finish;
  end

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    pix_if.valid      = 1'b0;
    pix_if.mask_on    = 1'b0;
    pix_if.first_ch0  = '0;
    pix_if.first_ch1  = '0;
    pix_if.first_ch2  = '0;
    pix_if.second_ch0 = '0;
    pix_if.second_ch1 = '0;
    pix_if.second_ch2 = '0;
    pix_if.last_pixel = 1'b0;
    res_if.ready = 1'b0;
    sum_acc      = '0;
    count_acc    = '0;
    channels_cfg = CHANNEL_COUNT_RST;
    fail_count   = 0;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    hold_left    = 0;
    stall_left   = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_setting();
    test_channel_counts();
    test_output_backpressure();
    test_random_frames(2'd2, 200, 1'b1);
    test_random_frames(2'd0, 60, 1'b1);
    test_random_frames(2'd1, 100, 1'b1);
    test_random_frames(2'd3, 230, 1'b1);
    test_random_frames(2'd3, 160, 1'b0);
    wait_idle();

    if (fail_count == 0 && rms_expected_q.size() == 0) begin
      $display("masked_rms_image_difference_unit test passed");
    end else begin
      $display("masked_rms_image_difference_unit test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/mrid_pkg.sv
hdl/mrid_pix_if.sv
hdl/mrid_res_if.sv
hdl/mrid_front.sv
hdl/mrid_queue.sv
hdl/mrid_back.sv
hdl/masked_rms_image_difference_unit.sv
test/tb_top.sv
